// ----- src/cppe_pkg.sv -----
// ----------------------------------------------------------------------------
// Bicycle power page engine package
// Shared codes, command and page types for the page engine.
// ----------------------------------------------------------------------------
package cppe_pkg;

  // Request type codes on the input
  localparam logic [2:0] REQ_POWER   = 3'd0;
  localparam logic [2:0] REQ_TORQUE  = 3'd1;
  localparam logic [2:0] REQ_FREQ    = 3'd2;
  localparam logic [2:0] REQ_BALANCE = 3'd3;
  localparam logic [2:0] REQ_PAGE    = 3'd4;

  // Data page ids
  localparam logic [7:0] PAGE_ID_STANDARD = 8'h10;
  localparam logic [7:0] PAGE_ID_WHEEL    = 8'h11;
  localparam logic [7:0] PAGE_ID_CRANK    = 8'h12;
  localparam logic [7:0] PAGE_ID_FREQ     = 8'h20;

  // Value for a field that is not reported
  localparam logic [7:0] NOT_REPORTED = 8'hFF;

  typedef enum logic [2:0] {
    CMD_POWER,
    CMD_TORQUE,
    CMD_FREQ,
    CMD_BALANCE,
    CMD_PAGE
  } cmd_kind_e;

  typedef enum logic [2:0] {
    SEL_STANDARD,
    SEL_WHEEL,
    SEL_CRANK,
    SEL_FREQ,
    SEL_UNKNOWN
  } page_sel_e;

  // One classified item: power uses opa/opbyte, torque opa/opb/crank,
  // frequency opa/opb, balance opbyte, page request sel
  typedef struct packed {
    cmd_kind_e   kind;
    page_sel_e   sel;
    logic        crank;
    logic [15:0] opa;
    logic [15:0] opb;
    logic [7:0]  opbyte;
  } cmd_t;

  // Command queue status toward the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic            err;
    logic [7:0][7:0] bytes;
  } page_t;

endpackage

// ----- src/cycling_power_page_engine_top.sv -----
// ----------------------------------------------------------------------------
// Bicycle power page engine
// Keeps bicycle power sensor records and returns 8-byte data pages.
// ----------------------------------------------------------------------------
// An item is taken on any cycle push is high and full is low, one per cycle
// sustained. Events are written into the command queue and update the
// records at the edge that takes them out of it, which can wait behind a
// stalled page request. A page request is built at the edge that takes it
// out of the command queue, once the page queue has room, and is on the
// result ports right after that edge when no older page waits there.
// A two-entry command queue and a two-entry page queue let the input keep
// flowing while pages wait to be popped; full rises only when both queues
// are stalled by the result side. Request types five to seven are taken and
// dropped. The slope register is written through the cfg channel, which is
// always ready; write it only while no item is in flight.
// ----------------------------------------------------------------------------
module cycling_power_page_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] power_watts_i,
  input  logic [7:0]  cadence_rpm_i,
  input  logic        crank_side_i,
  input  logic [15:0] period_ticks_i,
  input  logic [15:0] torque_amount_i,
  input  logic [15:0] time_increment_i,
  input  logic [15:0] tick_increment_i,
  input  logic [7:0]  balance_percent_i,
  input  logic [7:0]  page_number_i,
  output logic        empty,
  input  logic        pop,
  output logic        page_error_o,
  output logic [7:0]  page_byte_0_o,
  output logic [7:0]  page_byte_1_o,
  output logic [7:0]  page_byte_2_o,
  output logic [7:0]  page_byte_3_o,
  output logic [7:0]  page_byte_4_o,
  output logic [7:0]  page_byte_5_o,
  output logic [7:0]  page_byte_6_o,
  output logic [7:0]  page_byte_7_o
);

  logic                accept;
  logic                cmd_push;
  logic                cmd_pop;
  cppe_pkg::cmd_t      cmd;
  cppe_pkg::cmd_head_t head;
  cppe_pkg::page_t     page;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  cppe_front u_front (
    .accept_i          (accept),
    .req_type_i        (req_type_i),
    .power_watts_i     (power_watts_i),
    .cadence_rpm_i     (cadence_rpm_i),
    .crank_side_i      (crank_side_i),
    .period_ticks_i    (period_ticks_i),
    .torque_amount_i   (torque_amount_i),
    .time_increment_i  (time_increment_i),
    .tick_increment_i  (tick_increment_i),
    .balance_percent_i (balance_percent_i),
    .page_number_i     (page_number_i),
    .cmd_push_o        (cmd_push),
    .cmd_o             (cmd)
  );

  cppe_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd),
    .pop_i  (cmd_pop),
    .full_o (full),
    .head_o (head)
  );

  cppe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .head_i     (head),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .page_o     (page)
  );

  assign page_error_o  = page.err;
  assign page_byte_0_o = page.bytes[0];
  assign page_byte_1_o = page.bytes[1];
  assign page_byte_2_o = page.bytes[2];
  assign page_byte_3_o = page.bytes[3];
  assign page_byte_4_o = page.bytes[4];
  assign page_byte_5_o = page.bytes[5];
  assign page_byte_6_o = page.bytes[6];
  assign page_byte_7_o = page.bytes[7];

  // Back end never drains an empty command queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> head.valid)
    else $error("command popped from empty queue");

  // A queued command with an idle result side leaves the queue at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (head.valid && empty) |-> cmd_pop)
    else $error("command stalled with free output queue");

  // An error page carries all-zero bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && page_error_o) |-> (page.bytes == '0))
    else $error("error page with nonzero bytes");

  // A good page carries one of the known page ids
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (!empty && !page_error_o) |->
                   (page_byte_0_o == cppe_pkg::PAGE_ID_STANDARD ||
                    page_byte_0_o == cppe_pkg::PAGE_ID_WHEEL ||
                    page_byte_0_o == cppe_pkg::PAGE_ID_CRANK ||
                    page_byte_0_o == cppe_pkg::PAGE_ID_FREQ))
    else $error("page with unknown id not flagged");

endmodule

// ----- src/cppe_front.sv -----
// ----------------------------------------------------------------------------
// Page engine front end
// Classifies each input item into a compact command for the back end.
// ----------------------------------------------------------------------------
module cppe_front (
  input  logic                  accept_i,
  input  logic [2:0]            req_type_i,
  input  logic [15:0]           power_watts_i,
  input  logic [7:0]            cadence_rpm_i,
  input  logic                  crank_side_i,
  input  logic [15:0]           period_ticks_i,
  input  logic [15:0]           torque_amount_i,
  input  logic [15:0]           time_increment_i,
  input  logic [15:0]           tick_increment_i,
  input  logic [7:0]            balance_percent_i,
  input  logic [7:0]            page_number_i,
  output logic                  cmd_push_o,
  output cppe_pkg::cmd_t        cmd_o
);

  logic known;

  // Decode the request type and pick the operands
  always_comb begin
    known        = 1'b1;
    cmd_o        = '0;
    cmd_o.kind   = cppe_pkg::CMD_POWER;
    cmd_o.sel    = cppe_pkg::SEL_UNKNOWN;
    cmd_o.crank  = crank_side_i;
    unique case (req_type_i)
      cppe_pkg::REQ_POWER: begin
        cmd_o.kind   = cppe_pkg::CMD_POWER;
        cmd_o.opa    = power_watts_i;
        cmd_o.opbyte = cadence_rpm_i;
      end
      cppe_pkg::REQ_TORQUE: begin
        cmd_o.kind = cppe_pkg::CMD_TORQUE;
        cmd_o.opa  = period_ticks_i;
        cmd_o.opb  = torque_amount_i;
      end
      cppe_pkg::REQ_FREQ: begin
        cmd_o.kind = cppe_pkg::CMD_FREQ;
        cmd_o.opa  = time_increment_i;
        cmd_o.opb  = tick_increment_i;
      end
      cppe_pkg::REQ_BALANCE: begin
        cmd_o.kind   = cppe_pkg::CMD_BALANCE;
        cmd_o.opbyte = balance_percent_i;
      end
      cppe_pkg::REQ_PAGE: begin
        cmd_o.kind = cppe_pkg::CMD_PAGE;
      end
      default: begin
        known = 1'b0;
      end
    endcase

    // Map the page id to a page selector
    unique case (page_number_i)
      cppe_pkg::PAGE_ID_STANDARD: cmd_o.sel = cppe_pkg::SEL_STANDARD;
      cppe_pkg::PAGE_ID_WHEEL:    cmd_o.sel = cppe_pkg::SEL_WHEEL;
      cppe_pkg::PAGE_ID_CRANK:    cmd_o.sel = cppe_pkg::SEL_CRANK;
      cppe_pkg::PAGE_ID_FREQ:     cmd_o.sel = cppe_pkg::SEL_FREQ;
      default:                    cmd_o.sel = cppe_pkg::SEL_UNKNOWN;
    endcase
  end

  // Drop reserved request types
  assign cmd_push_o = accept_i && known;

endmodule

// ----- src/cppe_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// Page engine command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cppe_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cppe_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output logic                full_o,
  output cppe_pkg::cmd_head_t head_o
);

  cppe_pkg::cmd_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold the item in its slot
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- src/cppe_back.sv -----
// ----------------------------------------------------------------------------
// Page engine back end
// Updates the sensor records, builds pages and queues them for output.
// ----------------------------------------------------------------------------
module cppe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i,
  input  cppe_pkg::cmd_head_t head_i,
  output logic                cmd_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output cppe_pkg::page_t     page_o
);

  logic [15:0] slope_q;
  logic [7:0]  pwr_cnt_q;
  logic [15:0] pwr_sum_q;
  logic [15:0] pwr_now_q;
  logic [7:0]  cadence_q;
  logic [7:0]  balance_q;
  logic [7:0]  whl_cnt_q;
  logic [7:0]  whl_ticks_q;
  logic [15:0] whl_period_q;
  logic [15:0] whl_torque_q;
  logic [7:0]  crk_cnt_q;
  logic [7:0]  crk_ticks_q;
  logic [15:0] crk_period_q;
  logic [15:0] crk_torque_q;
  logic [7:0]  frq_cnt_q;
  logic [15:0] frq_time_q;
  logic [15:0] frq_ticks_q;

  cppe_pkg::page_t oq_q [2];
  logic            ow_ptr_q;
  logic            or_ptr_q;
  logic [1:0]      ocnt_q, ocnt_d;

  cppe_pkg::cmd_t  cmd;
  cppe_pkg::page_t page_new;
  logic            out_pop;
  logic            room;
  logic            is_page;
  logic            out_push;
  logic            apply;

  assign cmd      = head_i.cmd;
  assign is_page  = (cmd.kind == cppe_pkg::CMD_PAGE);
  assign out_pop  = pop_i && (ocnt_q != 2'd0);
  assign room     = (ocnt_q != 2'd2) || out_pop;

  // Stall only a page request that finds the output queue full
  assign cmd_pop_o = head_i.valid && (!is_page || room);
  assign apply     = cmd_pop_o && !is_page;
  assign out_push  = cmd_pop_o && is_page;

  assign empty_o = (ocnt_q == 2'd0);
  assign page_o  = oq_q[or_ptr_q];

  // Build the requested page from the current records
  always_comb begin
    page_new = '0;
    case (cmd.sel)
      cppe_pkg::SEL_STANDARD: begin
        page_new.bytes[0] = cppe_pkg::PAGE_ID_STANDARD;
        page_new.bytes[1] = pwr_cnt_q;
        page_new.bytes[2] = balance_q;
        page_new.bytes[3] = cadence_q;
        page_new.bytes[4] = pwr_sum_q[7:0];
        page_new.bytes[5] = pwr_sum_q[15:8];
        page_new.bytes[6] = pwr_now_q[7:0];
        page_new.bytes[7] = pwr_now_q[15:8];
      end
      cppe_pkg::SEL_WHEEL: begin
        page_new.bytes[0] = cppe_pkg::PAGE_ID_WHEEL;
        page_new.bytes[1] = whl_cnt_q;
        page_new.bytes[2] = whl_ticks_q;
        page_new.bytes[3] = cadence_q;
        page_new.bytes[4] = whl_period_q[7:0];
        page_new.bytes[5] = whl_period_q[15:8];
        page_new.bytes[6] = whl_torque_q[7:0];
        page_new.bytes[7] = whl_torque_q[15:8];
      end
      cppe_pkg::SEL_CRANK: begin
        page_new.bytes[0] = cppe_pkg::PAGE_ID_CRANK;
        page_new.bytes[1] = crk_cnt_q;
        page_new.bytes[2] = crk_ticks_q;
        page_new.bytes[3] = cadence_q;
        page_new.bytes[4] = crk_period_q[7:0];
        page_new.bytes[5] = crk_period_q[15:8];
        page_new.bytes[6] = crk_torque_q[7:0];
        page_new.bytes[7] = crk_torque_q[15:8];
      end
      cppe_pkg::SEL_FREQ: begin
        // Torque-frequency page is big-endian
        page_new.bytes[0] = cppe_pkg::PAGE_ID_FREQ;
        page_new.bytes[1] = frq_cnt_q;
        page_new.bytes[2] = slope_q[15:8];
        page_new.bytes[3] = slope_q[7:0];
        page_new.bytes[4] = frq_time_q[15:8];
        page_new.bytes[5] = frq_time_q[7:0];
        page_new.bytes[6] = frq_ticks_q[15:8];
        page_new.bytes[7] = frq_ticks_q[7:0];
      end
      default: begin
        page_new.err = 1'b1;
      end
    endcase
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q <= '0;
    end else if (cfg_we_i) begin
      slope_q <= cfg_data_i;
    end
  end

  // Update the sensor records
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwr_cnt_q    <= '0;
      pwr_sum_q    <= '0;
      pwr_now_q    <= '0;
      cadence_q    <= cppe_pkg::NOT_REPORTED;
      balance_q    <= cppe_pkg::NOT_REPORTED;
      whl_cnt_q    <= '0;
      whl_ticks_q  <= '0;
      whl_period_q <= '0;
      whl_torque_q <= '0;
      crk_cnt_q    <= '0;
      crk_ticks_q  <= '0;
      crk_period_q <= '0;
      crk_torque_q <= '0;
      frq_cnt_q    <= '0;
      frq_time_q   <= '0;
      frq_ticks_q  <= '0;
    end else if (apply) begin
      case (cmd.kind)
        cppe_pkg::CMD_POWER: begin
          pwr_cnt_q <= pwr_cnt_q + 8'd1;
          pwr_sum_q <= pwr_sum_q + cmd.opa;
          pwr_now_q <= cmd.opa;
          cadence_q <= cmd.opbyte;
        end
        cppe_pkg::CMD_TORQUE: begin
          if (cmd.crank) begin
            crk_cnt_q    <= crk_cnt_q + 8'd1;
            crk_ticks_q  <= crk_ticks_q + 8'd1;
            crk_period_q <= crk_period_q + cmd.opa;
            crk_torque_q <= crk_torque_q + cmd.opb;
          end else begin
            whl_cnt_q    <= whl_cnt_q + 8'd1;
            whl_ticks_q  <= whl_ticks_q + 8'd1;
            whl_period_q <= whl_period_q + cmd.opa;
            whl_torque_q <= whl_torque_q + cmd.opb;
          end
        end
        cppe_pkg::CMD_FREQ: begin
          frq_cnt_q   <= frq_cnt_q + 8'd1;
          frq_time_q  <= frq_time_q + cmd.opa;
          frq_ticks_q <= frq_ticks_q + cmd.opb;
        end
        cppe_pkg::CMD_BALANCE: begin
          balance_q <= cmd.opbyte;
        end
        default: begin
        end
      endcase
    end
  end

  // Output queue control
  always_comb begin
    ocnt_d = ocnt_q + {1'b0, out_push} - {1'b0, out_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ow_ptr_q <= 1'b0;
      or_ptr_q <= 1'b0;
      ocnt_q   <= 2'd0;
    end else begin
      ow_ptr_q <= out_push ? ~ow_ptr_q : ow_ptr_q;
      or_ptr_q <= out_pop  ? ~or_ptr_q : or_ptr_q;
      ocnt_q   <= ocnt_d;
    end
  end

  // Hold finished pages until taken
  always_ff @(posedge clk_i) begin
    if (out_push) begin
      oq_q[ow_ptr_q] <= page_new;
    end
  end

endmodule

// ----- test/cppe_checker.sv -----
// ----------------------------------------------------------------------------
// Bicycle power page checker
// Watches the item, page and slope channels of the page engine, keeps its
// own copy of the sensor records and compares every popped page with the
// page due for the oldest outstanding request.
// ----------------------------------------------------------------------------
module cppe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] power_watts_i,
  input  logic [7:0]  cadence_rpm_i,
  input  logic        crank_side_i,
  input  logic [15:0] period_ticks_i,
  input  logic [15:0] torque_amount_i,
  input  logic [15:0] time_increment_i,
  input  logic [15:0] tick_increment_i,
  input  logic [7:0]  balance_percent_i,
  input  logic [7:0]  page_number_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic        page_error_i,
  input  logic [7:0]  page_byte_0_i,
  input  logic [7:0]  page_byte_1_i,
  input  logic [7:0]  page_byte_2_i,
  input  logic [7:0]  page_byte_3_i,
  input  logic [7:0]  page_byte_4_i,
  input  logic [7:0]  page_byte_5_i,
  input  logic [7:0]  page_byte_6_i,
  input  logic [7:0]  page_byte_7_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          pages_checked_o
);

  // One wheel or crank torque record
  typedef struct {
    logic [7:0]  evt_count;
    logic [7:0]  tick_count;
    logic [15:0] period_sum;
    logic [15:0] torque_sum;
  } torque_rec_t;

  // Predicted sensor records and slope register
  logic [15:0] slope_q;
  logic [7:0]  pwr_count;
  logic [15:0] pwr_sum;
  logic [15:0] pwr_now;
  logic [7:0]  cadence_now;
  logic [7:0]  balance_now;
  torque_rec_t wheel_rec;
  torque_rec_t crank_rec;
  logic [7:0]  freq_count;
  logic [15:0] freq_stamp;
  logic [15:0] freq_ticks;

  // Pages owed to the result side, oldest first
  cppe_pkg::page_t pages_due[$];
  cppe_pkg::page_t seen_page;
  cppe_pkg::page_t want_page;
  int    fails = 0;
  int    checked = 0;

  function automatic torque_rec_t bump_record(torque_rec_t rec, logic [15:0] period,
                                              logic [15:0] torque);
    torque_rec_t nxt;
    nxt            = rec;
    nxt.evt_count  = rec.evt_count + 8'd1;
    nxt.tick_count = rec.tick_count + 8'd1;
    nxt.period_sum = rec.period_sum + period;
    nxt.torque_sum = rec.torque_sum + torque;
    return nxt;
  endfunction

  // Torque pages share one layout, sums little-endian
  function automatic cppe_pkg::page_t torque_page(logic [7:0] id, torque_rec_t rec);
    cppe_pkg::page_t pg;
    pg          = '0;
    pg.bytes[0] = id;
    pg.bytes[1] = rec.evt_count;
    pg.bytes[2] = rec.tick_count;
    pg.bytes[3] = cadence_now;
    pg.bytes[4] = rec.period_sum[7:0];
    pg.bytes[5] = rec.period_sum[15:8];
    pg.bytes[6] = rec.torque_sum[7:0];
    pg.bytes[7] = rec.torque_sum[15:8];
    return pg;
  endfunction

  // Build the page a request sees right now; unknown ids give an error page with all-zero bytes
  function automatic cppe_pkg::page_t build_page(logic [7:0] id);
    cppe_pkg::page_t pg;
    pg = '0;
    case (id)
      cppe_pkg::PAGE_ID_STANDARD: begin
        pg.bytes[0] = cppe_pkg::PAGE_ID_STANDARD;
        pg.bytes[1] = pwr_count;
        pg.bytes[2] = balance_now;
        pg.bytes[3] = cadence_now;
        pg.bytes[4] = pwr_sum[7:0];
        pg.bytes[5] = pwr_sum[15:8];
        pg.bytes[6] = pwr_now[7:0];
        pg.bytes[7] = pwr_now[15:8];
      end
      cppe_pkg::PAGE_ID_WHEEL: pg = torque_page(cppe_pkg::PAGE_ID_WHEEL, wheel_rec);
      cppe_pkg::PAGE_ID_CRANK: pg = torque_page(cppe_pkg::PAGE_ID_CRANK, crank_rec);
      cppe_pkg::PAGE_ID_FREQ: begin
        // Frequency page is big-endian
        pg.bytes[0] = cppe_pkg::PAGE_ID_FREQ;
        pg.bytes[1] = freq_count;
        pg.bytes[2] = slope_q[15:8];
        pg.bytes[3] = slope_q[7:0];
        pg.bytes[4] = freq_stamp[15:8];
        pg.bytes[5] = freq_stamp[7:0];
        pg.bytes[6] = freq_ticks[15:8];
        pg.bytes[7] = freq_ticks[7:0];
      end
      default: pg.err = 1'b1;
    endcase
    return pg;
  endfunction

  task automatic compare_page(cppe_pkg::page_t want, cppe_pkg::page_t got);
    if (want.err !== got.err) begin
      $display("%0t: page_error mismatch: expected %0b actual %0b",
               $time, want.err, got.err);
      fails++;
    end
    for (int i = 0; i < 8; i++) begin
      if (want.bytes[i] !== got.bytes[i]) begin
        $display("%0t: page_byte_%0d mismatch: expected %02h actual %02h",
                 $time, i, want.bytes[i], got.bytes[i]);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q     <= '0;
      pwr_count   <= '0;
      pwr_sum     <= '0;
      pwr_now     <= '0;
      cadence_now <= cppe_pkg::NOT_REPORTED;
      balance_now <= cppe_pkg::NOT_REPORTED;
      wheel_rec   <= '{default: '0};
      crank_rec   <= '{default: '0};
      freq_count  <= '0;
      freq_stamp  <= '0;
      freq_ticks  <= '0;
      pages_due.delete();
    end else begin
      // Check the popped page against the oldest one due
      if (pop_i && !empty_i) begin
        seen_page.err      = page_error_i;
        seen_page.bytes[0] = page_byte_0_i;
        seen_page.bytes[1] = page_byte_1_i;
        seen_page.bytes[2] = page_byte_2_i;
        seen_page.bytes[3] = page_byte_3_i;
        seen_page.bytes[4] = page_byte_4_i;
        seen_page.bytes[5] = page_byte_5_i;
        seen_page.bytes[6] = page_byte_6_i;
        seen_page.bytes[7] = page_byte_7_i;
        if (pages_due.size() == 0) begin
          $display("%0t: page popped with none due: expected nothing actual err %0b bytes %h",
                   $time, seen_page.err, seen_page.bytes);
          fails++;
        end else begin
          want_page = pages_due.pop_front();
          compare_page(want_page, seen_page);
          checked++;
        end
      end

      // Latch the slope register
      if (cfg_valid_i && cfg_ready_i) begin
        slope_q <= cfg_data_i;
      end

      // Advance the records for an accepted item
      if (push_i && !full_i) begin
        case (req_type_i)
          cppe_pkg::REQ_POWER: begin
            pwr_count   <= pwr_count + 8'd1;
            pwr_sum     <= pwr_sum + power_watts_i;
            pwr_now     <= power_watts_i;
            cadence_now <= cadence_rpm_i;
          end
          cppe_pkg::REQ_TORQUE: begin
            if (crank_side_i) begin
              crank_rec <= bump_record(crank_rec, period_ticks_i, torque_amount_i);
            end else begin
              wheel_rec <= bump_record(wheel_rec, period_ticks_i, torque_amount_i);
            end
          end
          cppe_pkg::REQ_FREQ: begin
            freq_count <= freq_count + 8'd1;
            freq_stamp <= freq_stamp + time_increment_i;
            freq_ticks <= freq_ticks + tick_increment_i;
          end
          cppe_pkg::REQ_BALANCE: balance_now <= balance_percent_i;
          cppe_pkg::REQ_PAGE:    pages_due.push_back(build_page(page_number_i));
          default: ;
        endcase
      end
    end
    fail_count_o    <= fails;
    pending_o       <= pages_due.size();
    pages_checked_o <= checked;
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Bicycle power page engine testbench
// Drives sensor events, balance updates and page requests into the engine
// with random gaps and pop stalls, rewrites the torque slope between phases
// and leaves all checking to the page checker.
// ----------------------------------------------------------------------------
module tb_top;

  // Request types the engine takes and drops
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
  localparam int         PHASE_ITEMS     = 200;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] watts;
    logic [7:0]  cadence;
    logic        crank;
    logic [15:0] period;
    logic [15:0] torque;
    logic [15:0] dtime;
    logic [15:0] dticks;
    logic [7:0]  balance;
    logic [7:0]  page;
  } sensor_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        push;
  logic        full;
  logic [2:0]  req_type;
  logic [15:0] power_watts;
  logic [7:0]  cadence_rpm;
  logic        crank_side;
  logic [15:0] period_ticks;
  logic [15:0] torque_amount;
  logic [15:0] time_increment;
  logic [15:0] tick_increment;
  logic [7:0]  balance_percent;
  logic [7:0]  page_number;
  logic        empty;
  logic        pop = 1'b0;
  logic        page_error;
  logic [7:0]  page_byte[8];

  int          fail_count;
  int          pages_pending;
  int          pages_checked;
  bit          calm = 1'b0;
  int          stall_left = 0;
  int          sensor_items = 0;
  int          spare_items = 0;
  int          slope_writes = 0;

  always #2 clk_i = ~clk_i;

  cycling_power_page_engine_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .push             (push),
    .full             (full),
    .req_type_i       (req_type),
    .power_watts_i    (power_watts),
    .cadence_rpm_i    (cadence_rpm),
    .crank_side_i     (crank_side),
    .period_ticks_i   (period_ticks),
    .torque_amount_i  (torque_amount),
    .time_increment_i (time_increment),
    .tick_increment_i (tick_increment),
    .balance_percent_i(balance_percent),
    .page_number_i    (page_number),
    .empty            (empty),
    .pop              (pop),
    .page_error_o     (page_error),
    .page_byte_0_o    (page_byte[0]),
    .page_byte_1_o    (page_byte[1]),
    .page_byte_2_o    (page_byte[2]),
    .page_byte_3_o    (page_byte[3]),
    .page_byte_4_o    (page_byte[4]),
    .page_byte_5_o    (page_byte[5]),
    .page_byte_6_o    (page_byte[6]),
    .page_byte_7_o    (page_byte[7])
  );

  cppe_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .push_i           (push),
    .full_i           (full),
    .req_type_i       (req_type),
    .power_watts_i    (power_watts),
    .cadence_rpm_i    (cadence_rpm),
    .crank_side_i     (crank_side),
    .period_ticks_i   (period_ticks),
    .torque_amount_i  (torque_amount),
    .time_increment_i (time_increment),
    .tick_increment_i (tick_increment),
    .balance_percent_i(balance_percent),
    .page_number_i    (page_number),
    .empty_i          (empty),
    .pop_i            (pop),
    .page_error_i     (page_error),
    .page_byte_0_i    (page_byte[0]),
    .page_byte_1_i    (page_byte[1]),
    .page_byte_2_i    (page_byte[2]),
    .page_byte_3_i    (page_byte[3]),
    .page_byte_4_i    (page_byte[4]),
    .page_byte_5_i    (page_byte[5]),
    .page_byte_6_i    (page_byte[6]),
    .page_byte_7_i    (page_byte[7]),
    .fail_count_o     (fail_count),
    .pending_o        (pages_pending),
    .pages_checked_o  (pages_checked)
  );

  // All fields random; page ids mostly known ones
  function automatic sensor_item_t random_item(bit power_heavy);
    sensor_item_t it;
    int roll;
    it.watts   = 16'($urandom);
    it.cadence = 8'($urandom);
    it.crank   = 1'($urandom);
    it.period  = 16'($urandom);
    it.torque  = 16'($urandom);
    it.dtime   = 16'($urandom);
    it.dticks  = 16'($urandom);
    it.balance = 8'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0:       it.page = cppe_pkg::PAGE_ID_STANDARD;
        1:       it.page = cppe_pkg::PAGE_ID_WHEEL;
        2:       it.page = cppe_pkg::PAGE_ID_CRANK;
        default: it.page = cppe_pkg::PAGE_ID_FREQ;
      endcase
    end else begin
      it.page = 8'($urandom);
    end
    roll = $urandom_range(0, 99);
    if (power_heavy) begin
      roll = (roll < 60) ? 0 : roll;
    end
    if (roll < 25) begin
      it.kind = cppe_pkg::REQ_POWER;
    end else if (roll < 50) begin
      it.kind = cppe_pkg::REQ_TORQUE;
    end else if (roll < 63) begin
      it.kind = cppe_pkg::REQ_FREQ;
    end else if (roll < 71) begin
      it.kind = cppe_pkg::REQ_BALANCE;
    end else if (roll < 96) begin
      it.kind = cppe_pkg::REQ_PAGE;
    end else begin
      it.kind = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    end
    return it;
  endfunction

  // Present one item at the falling edge and hold it until taken
  task automatic send_item(sensor_item_t it);
    req_type        <= it.kind;
    power_watts     <= it.watts;
    cadence_rpm     <= it.cadence;
    crank_side      <= it.crank;
    period_ticks    <= it.period;
    torque_amount   <= it.torque;
    time_increment  <= it.dtime;
    tick_increment  <= it.dticks;
    balance_percent <= it.balance;
    page_number     <= it.page;
    push            <= 1'b1;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    if (it.kind > cppe_pkg::REQ_PAGE) begin
      spare_items++;
    end else begin
      sensor_items++;
    end
    // Drop push for a short burst now and then
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  task automatic send_page(logic [7:0] id);
    sensor_item_t it;
    it      = random_item(1'b0);
    it.kind = cppe_pkg::REQ_PAGE;
    it.page = id;
    send_item(it);
  endtask

  task automatic send_power(logic [15:0] watts, logic [7:0] cadence);
    sensor_item_t it;
    it         = random_item(1'b0);
    it.kind    = cppe_pkg::REQ_POWER;
    it.watts   = watts;
    it.cadence = cadence;
    send_item(it);
  endtask

  task automatic send_torque(logic crank, logic [15:0] period, logic [15:0] torque);
    sensor_item_t it;
    it        = random_item(1'b0);
    it.kind   = cppe_pkg::REQ_TORQUE;
    it.crank  = crank;
    it.period = period;
    it.torque = torque;
    send_item(it);
  endtask

  task automatic send_freq(logic [15:0] dtime, logic [15:0] dticks);
    sensor_item_t it;
    it        = random_item(1'b0);
    it.kind   = cppe_pkg::REQ_FREQ;
    it.dtime  = dtime;
    it.dticks = dticks;
    send_item(it);
  endtask

  task automatic send_balance(logic [7:0] balance);
    sensor_item_t it;
    it         = random_item(1'b0);
    it.kind    = cppe_pkg::REQ_BALANCE;
    it.balance = balance;
    send_item(it);
  endtask

  // Hold push low until every page is back and events have drained
  task automatic settle();
    push <= 1'b0;
    while (pages_pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_slope(logic [15:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    slope_writes++;
  endtask

  // Result side: pop with random stall bursts, none in the calm phase
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      pop <= rst_ni;
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("cycling_power_page_engine_top regression: fail");
    $finish;
  end

  initial begin
    sensor_item_t it;
    sensor_item_t spare;
    logic [15:0]  slope_plan[4];
    int           sent;

    cfg_valid       = 1'b0;
    cfg_data        = '0;
    push            = 1'b0;
    req_type        = cppe_pkg::REQ_POWER;
    power_watts     = '0;
    cadence_rpm     = '0;
    crank_side      = 1'b0;
    period_ticks    = '0;
    torque_amount   = '0;
    time_increment  = '0;
    tick_increment  = '0;
    balance_percent = '0;
    page_number     = '0;
    slope_plan      = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h8001};

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Pages straight out of reset, including unknown ids
    send_page(cppe_pkg::PAGE_ID_STANDARD);
    send_page(cppe_pkg::PAGE_ID_FREQ);
    send_page(8'h00);
    send_page(8'hFF);
    // Wrap the power sum, cadence extremes
    send_power(16'hFFFF, 8'h00);
    send_power(16'hFFFF, cppe_pkg::NOT_REPORTED);
    send_balance(8'h00);
    send_page(cppe_pkg::PAGE_ID_STANDARD);
    // Wrap the wheel sums, load the crank record
    send_torque(1'b0, 16'hFFFF, 16'hFFFF);
    send_torque(1'b0, 16'h0001, 16'h0001);
    send_torque(1'b1, 16'hFFFF, 16'hFFFF);
    send_page(cppe_pkg::PAGE_ID_WHEEL);
    send_page(cppe_pkg::PAGE_ID_CRANK);
    send_freq(16'hFFFF, 16'hFFFF);
    send_freq(16'h0002, 16'h0001);
    send_page(cppe_pkg::PAGE_ID_FREQ);
    // Spare request types with every field but the page id at its top value are dropped
    spare = '{kind: REQ_SPARE_FIRST, watts: '1, cadence: '1, crank: 1'b1, period: '1,
              torque: '1, dtime: '1, dticks: '1, balance: '1,
              page: cppe_pkg::PAGE_ID_STANDARD};
    for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++) begin
      spare.kind = 3'(k);
      send_item(spare);
    end
    send_balance(cppe_pkg::NOT_REPORTED);
    send_power(16'h0000, 8'h5A);
    send_page(cppe_pkg::PAGE_ID_STANDARD);
    send_page(8'h13);
    send_page(8'h21);
    send_page(8'h0F);

    // Random phases, one slope setting each; the second leans on power events
    // and the last runs without idling
    for (int p = 0; p < 4; p++) begin
      settle();
      write_slope(slope_plan[p]);
      calm = (p == 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        it = random_item(p == 1);
        send_item(it);
        if (it.kind <= cppe_pkg::REQ_PAGE) begin
          sent++;
        end
      end
    end

    settle();
    repeat (4) @(negedge clk_i);
    $display("Covered %0d sensor items and %0d dropped spare items over %0d slope settings",
             sensor_items, spare_items, slope_writes);
    $display("Checked %0d pages, %0d mismatches", pages_checked, fail_count);
    if (fail_count == 0) begin
      $display("cycling_power_page_engine_top regression: pass");
    end else begin
      $display("cycling_power_page_engine_top regression: fail");
    end
    $finish;
  end

endmodule
